### hdl/block_bitmap_range_mark_macros.svh
// Assertion macros for the block bitmap range mark design.
`ifndef BLOCK_BITMAP_RANGE_MARK_MACROS_SVH
`define BLOCK_BITMAP_RANGE_MARK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBRM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbrm assertion failed");
`define BBRM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbrm assertion failed");
`else
`define BBRM_ASSERT_IMP(label, clk, rst, ante, cons)
`define BBRM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/bbrm_pkg.sv
// Shared constants, codes and types of the block bitmap range mark design.
package bbrm_pkg;

  localparam int WORD_BITS         = 64;
  localparam int WORD_LOG          = $clog2(WORD_BITS);
  localparam int NUM_WORDS_DEFAULT = 16;
  localparam int BLOCK_BYTES_DEF   = 1024;

  localparam int START_W  = 11;
  localparam int BYTE_W   = 21;
  localparam int WIDX_W   = 4;
  localparam int STATUS_W = 2;

  // Rounded-up byte count fits one more bit than the byte count.
  localparam int NW    = BYTE_W + 1;
  localparam int MUL_B_W = NW + 1;
  localparam int PROD_W  = NW + MUL_B_W;
  // Block positions: start plus count, one more bit.
  localparam int PW    = NW + 1;

  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  localparam logic REQ_MARK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLIP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] data;
    logic [STATUS_W-1:0]  status;
  } res_t;

endpackage

### hdl/bbrm_mul.sv
// Shared multiplier with a registered product, used for the block count division.
module bbrm_mul (
  input  logic                        clk,
  input  logic [bbrm_pkg::NW-1:0]     a,
  input  logic [bbrm_pkg::MUL_B_W-1:0] b,
  output logic [bbrm_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= bbrm_pkg::PROD_W'(a) * bbrm_pkg::PROD_W'(b);
  end

endmodule

### hdl/bbrm_ram.sv
// Bitmap word memory with one write port and one registered read port.
module bbrm_ram #(
  parameter int NUM_WORDS = bbrm_pkg::NUM_WORDS_DEFAULT,
  parameter int AW        = 4
) (
  input  logic                           clk,
  input  bbrm_pkg::ram_ctl_t             ctl,
  input  logic [AW-1:0]                  rd_addr,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [bbrm_pkg::WORD_BITS-1:0] wr_data,
  output logic [bbrm_pkg::WORD_BITS-1:0] rd_data
);

  logic [bbrm_pkg::WORD_BITS-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/bbrm_ctrl.sv
// Request sequencer: block count division, range clipping and word-by-word update.
module bbrm_ctrl #(
  parameter int NUM_WORDS   = bbrm_pkg::NUM_WORDS_DEFAULT,
  parameter int BLOCK_BYTES = bbrm_pkg::BLOCK_BYTES_DEF,
  parameter int AW          = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            req_type,
  input  logic [bbrm_pkg::START_W-1:0]    start_block,
  input  logic [bbrm_pkg::BYTE_W-1:0]     byte_count,
  input  logic                            mark_value,
  input  logic [bbrm_pkg::WIDX_W-1:0]     word_index,
  input  logic                            res_ready,
  output logic                            idle,
  output bbrm_pkg::res_t                  res,
  output bbrm_pkg::ram_ctl_t              ram_ctl,
  output logic [AW-1:0]                   rd_addr,
  output logic [AW-1:0]                   wr_addr,
  output logic [bbrm_pkg::WORD_BITS-1:0]  wr_data,
  input  logic [bbrm_pkg::WORD_BITS-1:0]  rd_data,
  output logic [bbrm_pkg::NW-1:0]         mul_a,
  output logic [bbrm_pkg::MUL_B_W-1:0]    mul_b,
  input  logic [bbrm_pkg::PROD_W-1:0]     prod
);

  localparam int NW = bbrm_pkg::NW;
  localparam int PW = bbrm_pkg::PW;
  localparam int WB = bbrm_pkg::WORD_BITS;
  localparam int WL = bbrm_pkg::WORD_LOG;

  localparam logic [bbrm_pkg::MUL_B_W-1:0] RECIP =
    bbrm_pkg::MUL_B_W'((64'd1 << NW) / BLOCK_BYTES);
  localparam logic [bbrm_pkg::MUL_B_W-1:0] BLOCK_B = bbrm_pkg::MUL_B_W'(BLOCK_BYTES);
  localparam logic [NW-1:0] BLOCK_N   = NW'(BLOCK_BYTES);
  localparam logic [NW-1:0] ROUND_ADD = NW'(BLOCK_BYTES - 1);
  localparam logic [PW-1:0] TOTAL     = PW'(NUM_WORDS * WB);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_RDCAP = 11'b00000001000,
    S_DIV1  = 11'b00000010000,
    S_DIV2  = 11'b00000100000,
    S_DIV3  = 11'b00001000000,
    S_RANGE = 11'b00010000000,
    S_SPAN  = 11'b00100000000,
    S_WORD  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;

  logic [bbrm_pkg::START_W-1:0]      first;
  logic                              mark;
  logic [bbrm_pkg::WIDX_W-1:0]       widx;
  logic [NW-1:0]                     nbytes;
  logic [NW-1:0]                     qest;
  logic [NW-1:0]                     count;
  logic [PW-1:0]                     end_pos;
  logic [bbrm_pkg::STATUS_W-1:0]     status;
  logic [WB-1:0]                     res_data;
  logic                              rd_hit;
  logic [AW-1:0]                     first_word;
  logic [AW-1:0]                     last_word;
  logic [WL-1:0]                     lo_off;
  logic [WL:0]                       hi_off;
  logic [AW-1:0]                     rd_ptr;
  logic                              issuing;
  logic                              pend_valid;
  logic [AW-1:0]                     pend_addr;

  logic [NW-1:0]  rem;
  logic [PW-1:0]  end_raw;
  logic [PW-1:0]  last_pos;
  logic           widx_hit;
  logic [WL-1:0]  m_lo;
  logic [WL:0]    m_hi;
  logic [WB-1:0]  mask;

  assign rem      = nbytes - prod[NW-1:0];
  assign end_raw  = PW'(first) + PW'(count);
  assign last_pos = end_pos - PW'(1);
  assign widx_hit = (32'(widx) < NUM_WORDS);

  // Mask of the covered bits within the word being written back.
  assign m_lo = (pend_addr == first_word) ? lo_off : '0;
  assign m_hi = (pend_addr == last_word) ? hi_off : (WL+1)'(WB);
  assign mask = (bbrm_pkg::ALL_ONES << m_lo) & ~(bbrm_pkg::ALL_ONES << m_hi);

  always_comb begin
    idle       = (state == S_IDLE);
    res.valid  = (state == S_DONE);
    res.data   = res_data;
    res.status = status;

    mul_a = (state == S_DIV1) ? nbytes : prod[NW +: NW];
    mul_b = (state == S_DIV1) ? RECIP : BLOCK_B;

    ram_ctl.rd_en = ((state == S_RD) && widx_hit) || ((state == S_WORD) && issuing);
    ram_ctl.wr_en = (state == S_CLEAR) || ((state == S_WORD) && pend_valid);
    rd_addr = (state == S_RD) ? AW'(widx) : rd_ptr;
    wr_addr = (state == S_CLEAR) ? rd_ptr : pend_addr;
    if (state == S_CLEAR) begin
      wr_data = bbrm_pkg::ALL_ONES;
    end else if (mark) begin
      wr_data = rd_data | mask;
    end else begin
      wr_data = rd_data & ~mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      rd_ptr     <= '0;
      issuing    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == S_WORD) && issuing;
      unique case (state)
        S_CLEAR: begin
          if (rd_ptr == LAST_ADDR) begin
            rd_ptr <= '0;
            state  <= S_IDLE;
          end else begin
            rd_ptr <= rd_ptr + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            if (req_type == bbrm_pkg::REQ_READ) begin
              state <= S_RD;
            end else if (start_block == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_RD:    state <= S_RDCAP;
        S_RDCAP: state <= S_DONE;
        S_DIV1:  state <= S_DIV2;
        S_DIV2:  state <= S_DIV3;
        S_DIV3:  state <= S_RANGE;
        S_RANGE: state <= S_SPAN;
        S_SPAN: begin
          rd_ptr  <= AW'(first >> WL);
          issuing <= (PW'(first) < end_pos);
          state   <= (PW'(first) < end_pos) ? S_WORD : S_DONE;
        end
        S_WORD: begin
          // Reads run one word ahead of the write-back of the previous word.
          if (issuing) begin
            if (rd_ptr == last_word) begin
              issuing <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr + AW'(1);
            end
          end
          if (!issuing && !pend_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= rd_ptr;
    unique case (state)
      S_IDLE: begin
        first    <= start_block - bbrm_pkg::START_W'(1);
        mark     <= mark_value;
        widx     <= word_index;
        nbytes   <= NW'(byte_count) + ROUND_ADD;
        res_data <= '0;
        status   <= (req_type == bbrm_pkg::REQ_MARK && start_block == '0) ?
                    bbrm_pkg::ST_ZERO : bbrm_pkg::ST_DONE;
      end
      S_RD: rd_hit <= widx_hit;
      S_RDCAP: res_data <= rd_hit ? rd_data : '0;
      S_DIV2: qest <= prod[NW +: NW];
      S_DIV3: count <= qest + NW'(rem >= BLOCK_N);
      S_RANGE: begin
        if (end_raw > TOTAL) begin
          status  <= bbrm_pkg::ST_CLIP;
          end_pos <= TOTAL;
        end else begin
          end_pos <= end_raw;
        end
      end
      S_SPAN: begin
        first_word <= AW'(first >> WL);
        last_word  <= AW'(last_pos >> WL);
        lo_off     <= first[WL-1:0];
        hi_off     <= (WL+1)'(last_pos[WL-1:0]) + (WL+1)'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/block_bitmap_range_mark.sv
// Top level of the block bitmap range mark: handshake, result register and checks.
//
// A bitmap of NUM_WORDS 64-bit words keeps one bit per block; every bit reads as one
// after reset. After reset a clearing pass writes all ones into the word memory, one
// word per cycle, with in_ready low until it ends. A mark request (req_type
// 0) rounds byte_count up to whole blocks of BLOCK_BYTES and writes mark_value into
// that many blocks from the 1-based start_block; blocks past the end are dropped with
// status 1, and start block zero is rejected with status 2. A read request (req_type
// 1) returns one word, or zero for a word_index past the end. One request is worked
// on at a time. A read passes through S_RD and S_RDCAP to S_DONE. A mark runs
// through S_DIV1, S_DIV2, S_DIV3, S_RANGE and S_SPAN, then updates each bitmap word
// it covers in S_WORD, skipped when it covers no block; the division uses one shared
// multiplier twice, and the words are updated through the single read and write port
// of the memory, one word per cycle. A rejected start block goes from S_IDLE straight
// to S_DONE. The result register lets the next request be taken while a result waits.
`include "block_bitmap_range_mark_macros.svh"

module block_bitmap_range_mark #(
  parameter int NUM_WORDS   = bbrm_pkg::NUM_WORDS_DEFAULT,
  parameter int BLOCK_BYTES = bbrm_pkg::BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [bbrm_pkg::START_W-1:0]    start_block,
  input  logic [bbrm_pkg::BYTE_W-1:0]     byte_count,
  input  logic                            mark_value,
  input  logic [bbrm_pkg::WIDX_W-1:0]     word_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bbrm_pkg::WORD_BITS-1:0]  word_data,
  output logic [bbrm_pkg::STATUS_W-1:0]   status
);

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  bbrm_pkg::res_t                  res;
  bbrm_pkg::ram_ctl_t              ram_ctl;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   wr_addr;
  logic [bbrm_pkg::WORD_BITS-1:0]  wr_data;
  logic [bbrm_pkg::WORD_BITS-1:0]  rd_data;
  logic [bbrm_pkg::NW-1:0]         mul_a;
  logic [bbrm_pkg::MUL_B_W-1:0]    mul_b;
  logic [bbrm_pkg::PROD_W-1:0]     prod;
  logic                            idle;
  logic                            res_ready;
  logic                            start;

  assign start     = in_valid && in_ready;
  assign in_ready  = idle;
  assign res_ready = !out_valid || out_ready;

  bbrm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bbrm_ram #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  bbrm_ctrl #(
    .NUM_WORDS   (NUM_WORDS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .start_block (start_block),
    .byte_count  (byte_count),
    .mark_value  (mark_value),
    .word_index  (word_index),
    .res_ready   (res_ready),
    .idle        (idle),
    .res         (res),
    .ram_ctl     (ram_ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .prod        (prod)
  );

  // Result register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      word_data <= res.data;
      status    <= res.status;
    end
  end

  `BBRM_ASSERT_NXT(a_busy_after_transfer, clk, rst, in_valid && in_ready, !in_ready)
  `BBRM_ASSERT_IMP(a_status_code, clk, rst, out_valid,
    status == bbrm_pkg::ST_DONE || status == bbrm_pkg::ST_CLIP ||
    status == bbrm_pkg::ST_ZERO)
  `BBRM_ASSERT_IMP(a_mark_data_zero, clk, rst,
    out_valid && status != bbrm_pkg::ST_DONE, word_data == '0)

endmodule

### tb/tb_block_bitmap_range_mark.sv
// Self-checking testbench for the block bitmap range mark with a bit-level bitmap predictor.
`timescale 1ns / 100ps

module tb_block_bitmap_range_mark;

  localparam int NUM_WORDS    = bbrm_pkg::NUM_WORDS_DEFAULT;
  localparam int BLOCK_BYTES  = bbrm_pkg::BLOCK_BYTES_DEF;
  localparam int WORD_BITS    = bbrm_pkg::WORD_BITS;
  localparam int START_W      = bbrm_pkg::START_W;
  localparam int BYTE_W       = bbrm_pkg::BYTE_W;
  localparam int WIDX_W       = bbrm_pkg::WIDX_W;
  localparam int STATUS_W     = bbrm_pkg::STATUS_W;
  localparam int TOTAL_BLOCKS = NUM_WORDS * WORD_BITS;
  localparam int MAX_WAIT     = 18;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 580;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [WORD_BITS-1:0] word;
    logic [STATUS_W-1:0]  status;
  } response_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = bbrm_pkg::REQ_MARK;
  logic [START_W-1:0]   start_block = '0;
  logic [BYTE_W-1:0]    byte_count = '0;
  logic                 mark_value = 1'b0;
  logic [WIDX_W-1:0]    word_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_BITS-1:0] word_data;
  logic [STATUS_W-1:0]  status;

  logic [WORD_BITS-1:0] bitmap_model [NUM_WORDS];
  response_t            awaited_responses [$];

  // When set, neither side inserts wait cycles.
  bit no_idle = 1'b0;
  int error_count = 0;
  int reported = 0;
  int checked = 0;
  int idle_cycles = 0;
  int mark_count = 0;
  int read_count = 0;
  int clip_count = 0;
  int reject_count = 0;

  block_bitmap_range_mark #(
    .NUM_WORDS   (NUM_WORDS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .start_block (start_block),
    .byte_count  (byte_count),
    .mark_value  (mark_value),
    .word_index  (word_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .word_data   (word_data),
    .status      (status)
  );

  always #2 clk = ~clk;

  // Applies one request to the bitmap model and returns the response it must produce.
  function automatic response_t apply_request(logic rt, logic [START_W-1:0] sb,
                                              logic [BYTE_W-1:0] bc, logic mv,
                                              logic [WIDX_W-1:0] wi);
    response_t   r;
    int unsigned blocks;
    int unsigned first_blk;
    int unsigned end_blk;
    r.word = '0;
    r.status = bbrm_pkg::ST_DONE;
    if (rt == bbrm_pkg::REQ_READ) begin
      read_count++;
      r.word = (wi < NUM_WORDS) ? bitmap_model[wi] : '0;
      return r;
    end
    mark_count++;
    if (sb == '0) begin
      reject_count++;
      r.status = bbrm_pkg::ST_ZERO;
      return r;
    end
    blocks = (int'(bc) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    first_blk = sb - 1;
    end_blk = first_blk + blocks;
    if (end_blk > TOTAL_BLOCKS) begin
      clip_count++;
      r.status = bbrm_pkg::ST_CLIP;
      end_blk = TOTAL_BLOCKS;
    end
    for (int unsigned b = first_blk; b < end_blk; b++) begin
      bitmap_model[WIDX_W'(b / WORD_BITS)][bbrm_pkg::WORD_LOG'(b % WORD_BITS)] = mv;
    end
    return r;
  endfunction

  // Presents one request and returns at the falling edge after its transfer.
  task automatic issue_request(input logic rt, input logic [START_W-1:0] sb,
                               input logic [BYTE_W-1:0] bc, input logic mv,
                               input logic [WIDX_W-1:0] wi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    start_block <= sb;
    byte_count <= bc;
    mark_value <= mv;
    word_index <= wi;
    @(posedge clk);
    while ((in_valid && in_ready) !== 1'b1) @(posedge clk);
    awaited_responses.push_back(apply_request(rt, sb, bc, mv, wi));
    @(negedge clk);
  endtask

  task automatic read_word(input logic [WIDX_W-1:0] wi);
    issue_request(bbrm_pkg::REQ_READ, START_W'($urandom), BYTE_W'($urandom),
                  1'($urandom), wi);
  endtask

  task automatic mark_range(input logic [START_W-1:0] sb, input logic [BYTE_W-1:0] bc,
                            input logic mv);
    issue_request(bbrm_pkg::REQ_MARK, sb, bc, mv, WIDX_W'($urandom));
  endtask

  task automatic test_reset_contents();
    read_word(0);
    read_word(WIDX_W'(NUM_WORDS - 1));
  endtask

  task automatic test_start_zero();
    mark_range(0, '1, 1'b0);
    read_word(0);
  endtask

  task automatic test_zero_bytes();
    mark_range(5, 0, 1'b0);
  endtask

  task automatic test_partial_words();
    mark_range(3, 1, 1'b0);
    // Ten blocks that straddle the boundary between word 0 and word 1.
    mark_range(60, BYTE_W'(10 * BLOCK_BYTES), 1'b0);
    read_word(0);
    read_word(1);
  endtask

  task automatic test_whole_words();
    mark_range(START_W'(WORD_BITS + 1), BYTE_W'(2 * WORD_BITS * BLOCK_BYTES), 1'b0);
    read_word(1);
    read_word(2);
  endtask

  task automatic test_range_clip();
    mark_range(1000, '1, 1'b0);
    mark_range(START_W'(TOTAL_BLOCKS + 1), 0, 1'b1);
    mark_range('1, BYTE_W'(BLOCK_BYTES), 1'b1);
    read_word(WIDX_W'(NUM_WORDS - 1));
  endtask

  task automatic test_full_bitmap();
    mark_range(1, BYTE_W'(TOTAL_BLOCKS * BLOCK_BYTES), 1'b1);
    // One byte more rounds up to a block past the end.
    mark_range(1, BYTE_W'(TOTAL_BLOCKS * BLOCK_BYTES + 1), 1'b0);
    read_word(7);
  endtask

  task automatic test_random_traffic();
    int                 kind;
    int                 sel;
    int                 blocks;
    logic [START_W-1:0] sb;
    logic [BYTE_W-1:0]  bc;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        read_word(WIDX_W'($urandom));
      end else begin
        sel = $urandom_range(0, 19);
        if (sel == 0) sb = '0;
        else if (sel == 1) sb = START_W'($urandom_range(TOTAL_BLOCKS + 1, 2 ** START_W - 1));
        else if (sel == 2) sb = START_W'(($urandom_range(0, 1) == 0) ? 1 : TOTAL_BLOCKS);
        else sb = START_W'($urandom_range(1, TOTAL_BLOCKS));
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          bc = '0;
        end else if (sel == 1) begin
          bc = BYTE_W'($urandom);
        end else if (sel == 2) begin
          bc = BYTE_W'($urandom_range(0, TOTAL_BLOCKS * BLOCK_BYTES));
        end else begin
          // Mostly short runs with a partial last block.
          blocks = $urandom_range(1, 150);
          bc = BYTE_W'(blocks * BLOCK_BYTES - $urandom_range(0, BLOCK_BYTES - 1));
        end
        mark_range(sb, bc, 1'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls on out_ready, then compares each transfer in order.
  initial begin
    int        stall;
    response_t want;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while ((out_valid && out_ready) !== 1'b1) @(posedge clk);
      checked++;
      if (awaited_responses.size() == 0) begin
        error_count++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: unrequested result word=%h status=%0d at %0t",
                   word_data, status, $realtime);
        end
      end else begin
        want = awaited_responses.pop_front();
        if (word_data !== want.word || status !== want.status) begin
          error_count++;
          if (reported < 10) begin
            reported++;
            $display("ERROR: result %0d word exp=%h got=%h status exp=%0d got=%0d at %0t",
                     checked, want.word, word_data, want.status, status, $realtime);
          end
        end
      end
      @(negedge clk);
    end
  end

  // Ends a run in which no transfer happens for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Timeout: no transfer in %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_responses.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int w = 0; w < NUM_WORDS; w++) bitmap_model[WIDX_W'(w)] = bbrm_pkg::ALL_ONES;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_reset_contents();
    test_start_zero();
    test_zero_bytes();
    test_partial_words();
    test_whole_words();
    test_range_clip();
    test_full_bitmap();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += awaited_responses.size();
    $display("Covered %0d mark requests (%0d clipped, %0d rejected) and %0d word reads.",
             mark_count, clip_count, reject_count, read_count);
    $display("Compared %0d results, %0d mismatches or missing.", checked, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
